@@ rtl/manchester_frame_transmitter_macros.svh @@
// Assertion macros used by the checker file of the Manchester frame transmitter.
`ifndef MANCHESTER_FRAME_TRANSMITTER_MACROS_SVH
`define MANCHESTER_FRAME_TRANSMITTER_MACROS_SVH

// Checked at every rising edge outside of reset.
`define MFT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("manchester_frame_transmitter: assertion failed");

// Checked at every rising edge while reset is released, without disabling.
`define MFT_ASSERT_RST(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) !rstn || (prop)) \
		else $error("manchester_frame_transmitter: reset assertion failed");

`endif

@@ rtl/mft_pkg.sv @@
// Types and constants of the Manchester frame transmitter.
package mft_pkg;

	localparam int FRAME_BITS = 32;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SEND = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [2:0]  msg_type;
		logic [7:0]  data_id;
		logic [15:0] data_value;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic accepted;
		logic frame_end;
	} res_t;

endpackage

@@ rtl/mft_encoder.sv @@
// Frame state, frame word builder and half-bit line encoder.
module mft_encoder #(
	parameter int GUARD_HALF_BITS = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  mft_pkg::item_t item,
	output mft_pkg::res_t  res
);

	localparam int TOTAL = 2 * GUARD_HALF_BITS + 2 * mft_pkg::FRAME_BITS;
	localparam int POS_W = $clog2(TOTAL);
	localparam logic [POS_W-1:0] GUARD_P = POS_W'(GUARD_HALF_BITS);
	localparam logic [POS_W-1:0] DATA_HB = POS_W'(2 * mft_pkg::FRAME_BITS);
	localparam logic [POS_W-1:0] LAST_P = POS_W'(TOTAL - 1);

	logic [mft_pkg::FRAME_BITS-1:0] frame_q;
	logic [POS_W-1:0]               pos_q;
	logic                           sending_q;
	logic                           last_level_q;

	logic [mft_pkg::FRAME_BITS-1:0] frame_d;
	logic [POS_W-1:0]               pos_d;
	logic                           sending_d;
	logic                           last_level_d;
	logic [POS_W-1:0]               j;
	logic                           data_phase;
	logic                           tick_level;
	logic [27:0]                    upper;

	assign upper = {1'b1, item.msg_type, item.data_id, item.data_value};
	assign j = pos_q - GUARD_P;
	assign data_phase = (pos_q >= GUARD_P) && (j < DATA_HB);
	assign tick_level = data_phase ? (frame_q[~j[5:1]] ^ j[0]) : 1'b1;

	always_comb begin
		frame_d = frame_q;
		pos_d = pos_q;
		sending_d = sending_q;
		last_level_d = last_level_q;
		res.line_level = 1'b1;
		res.accepted = 1'b0;
		res.frame_end = 1'b0;
		if (item.kind == mft_pkg::KIND_SEND) begin
			if (!sending_q) begin
				frame_d = {upper, 3'b000, ^upper};
				pos_d = '0;
				sending_d = 1'b1;
				last_level_d = 1'b1;
				res.accepted = 1'b1;
			end else begin
				res.line_level = last_level_q;
			end
		end else if (sending_q) begin
			res.line_level = tick_level;
			last_level_d = tick_level;
			if (pos_q >= LAST_P) begin
				res.frame_end = 1'b1;
				sending_d = 1'b0;
				pos_d = '0;
			end else begin
				pos_d = pos_q + POS_W'(1);
			end
		end
		res.busy_res = sending_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			pos_q <= '0;
			sending_q <= 1'b0;
			last_level_q <= 1'b1;
		end else if (step) begin
			frame_q <= frame_d;
			pos_q <= pos_d;
			sending_q <= sending_d;
			last_level_q <= last_level_d;
		end
	end

endmodule

@@ rtl/manchester_frame_transmitter.sv @@
// Top level of the Manchester frame transmitter with input and result registers.
//  channel | direction | handshake             | payload
//  req     | in        | req_valid, req_stall  | kind, msg_type, data_id, data_value
//  res     | out       | res_valid, res_stall  | line_level, busy_res, accepted, frame_end
// One transaction is taken per cycle while req_stall is low, and its result is registered.
// The frame state advances when the input register hands its item to the result register.
// A stall on the result side holds both registers and raises req_stall once they are full.
// Reset clears the frame state and both valid flags; the first frame starts from a high line.
module manchester_frame_transmitter #(
	parameter int GUARD_HALF_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        kind,
	input  logic [2:0]  msg_type,
	input  logic [7:0]  data_id,
	input  logic [15:0] data_value,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        line_level,
	output logic        busy_res,
	output logic        accepted,
	output logic        frame_end
);

	mft_pkg::item_t item_s1;
	logic           valid_s1;
	mft_pkg::res_t  res_comb;
	mft_pkg::res_t  res_s2;
	logic           valid_s2;
	logic           advance;

	assign advance = valid_s1 && (!valid_s2 || !res_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= '{kind: kind, msg_type: msg_type, data_id: data_id,
				data_value: data_value};
		end
	end

	mft_encoder #(
		.GUARD_HALF_BITS(GUARD_HALF_BITS)
	) u_encoder (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (item_s1),
		.res   (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !res_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid = valid_s2;
	assign line_level = res_s2.line_level;
	assign busy_res = res_s2.busy_res;
	assign accepted = res_s2.accepted;
	assign frame_end = res_s2.frame_end;

endmodule

@@ rtl/mft_checker.sv @@
// Port-level checker of the Manchester frame transmitter and its bind statement.
`include "manchester_frame_transmitter_macros.svh"

module mft_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input logic line_level,
	input logic busy_res,
	input logic accepted,
	input logic frame_end
);

	`MFT_ASSERT(a_res_hold, clk, arst_n, res_valid && res_stall |=> res_valid && $stable({line_level, busy_res, accepted, frame_end}))
	`MFT_ASSERT(a_accept_busy_high, clk, arst_n, res_valid && accepted |-> busy_res && line_level && !frame_end)
	`MFT_ASSERT(a_end_idle, clk, arst_n, res_valid && frame_end |-> !busy_res && line_level)
	`MFT_ASSERT_RST(a_idle_high, clk, arst_n, !res_valid || busy_res || line_level)

endmodule

bind manchester_frame_transmitter mft_checker u_mft_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.line_level(line_level),
	.busy_res  (busy_res),
	.accepted  (accepted),
	.frame_end (frame_end)
);

@@ bench/tb.sv @@
// Self-checking testbench for the Manchester frame transmitter, with a line-level scoreboard.
module tb;

	localparam int GUARD_HALF_BITS = 6;
	localparam int HALF_BITS_PER_FRAME = 2 * GUARD_HALF_BITS + 2 * mft_pkg::FRAME_BITS;
	localparam int SEND_TARGET = 1500;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int HOLDOFF_AFTER = 400;
	localparam int REPORT_LIMIT = 10;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	class line_scoreboard_t;
		logic [31:0] frame_word = '0;
		logic [6:0] half_pos = '0;
		bit sending = 1'b0;
		mft_pkg::res_t pending[$];
		int unsigned errors = 0;

		function logic level_at(int unsigned idx);
			int unsigned j;
			logic b;
			if (idx < GUARD_HALF_BITS)
				return 1'b1;
			j = idx - GUARD_HALF_BITS;
			if (j >= 2 * mft_pkg::FRAME_BITS)
				return 1'b1;
			b = frame_word[31 - j / 2];
			return j[0] ? ~b : b;
		endfunction

		function void note_transaction(mft_pkg::item_t it);
			mft_pkg::res_t r;
			r = '0;
			r.line_level = 1'b1;
			if (it.kind == mft_pkg::KIND_SEND) begin
				if (!sending) begin
					frame_word = {1'b1, it.msg_type, it.data_id, it.data_value, 4'b0000};
					frame_word[0] = ^frame_word[31:1];
					half_pos = '0;
					sending = 1'b1;
					r.accepted = 1'b1;
				end else begin
					r.line_level = (half_pos == 0) ? 1'b1 : level_at(half_pos - 1);
				end
			end else if (sending) begin
				r.line_level = level_at(half_pos);
				if (half_pos >= HALF_BITS_PER_FRAME - 1) begin
					r.frame_end = 1'b1;
					sending = 1'b0;
					half_pos = '0;
				end else begin
					half_pos = half_pos + 1'b1;
				end
			end
			r.busy_res = sending;
			pending.push_back(r);
		endfunction

		function void check_result(mft_pkg::res_t got);
			mft_pkg::res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("Result with no transaction pending: line=%b busy=%b acc=%b end=%b",
						got.line_level, got.busy_res, got.accepted, got.frame_end);
				return;
			end
			want = pending.pop_front();
			if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
					got.accepted !== want.accepted || got.frame_end !== want.frame_end) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("Mismatch: want line=%b busy=%b acc=%b end=%b, %s%b busy=%b acc=%b end=%b",
						want.line_level, want.busy_res, want.accepted, want.frame_end,
						"got line=", got.line_level, got.busy_res, got.accepted,
						got.frame_end);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic kind = mft_pkg::KIND_TICK;
	logic [2:0] msg_type = '0;
	logic [7:0] data_id = '0;
	logic [15:0] data_value = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic line_level;
	logic busy_res;
	logic accepted;
	logic frame_end;

	line_scoreboard_t sb = new;
	int unsigned results_seen = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;

	manchester_frame_transmitter #(
		.GUARD_HALF_BITS(GUARD_HALF_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.msg_type(msg_type),
		.data_id(data_id),
		.data_value(data_value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.line_level(line_level),
		.busy_res(busy_res),
		.accepted(accepted),
		.frame_end(frame_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic mft_pkg::item_t tick_item();
		mft_pkg::item_t it;
		it.kind = mft_pkg::KIND_TICK;
		it.msg_type = 3'($urandom_range(0, 7));
		it.data_id = 8'($urandom_range(0, 255));
		it.data_value = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic mft_pkg::item_t request_item(logic [2:0] mt, logic [7:0] id,
			logic [15:0] val);
		mft_pkg::item_t it;
		it.kind = mft_pkg::KIND_SEND;
		it.msg_type = mt;
		it.data_id = id;
		it.data_value = val;
		return it;
	endfunction

	function automatic mft_pkg::item_t random_request();
		mft_pkg::item_t it;
		it = tick_item();
		it.kind = mft_pkg::KIND_SEND;
		if ($urandom_range(0, 7) == 0)
			it.msg_type = $urandom_range(0, 1) ? 3'h7 : 3'h0;
		if ($urandom_range(0, 7) == 0)
			it.data_id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 7) == 0)
			it.data_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return it;
	endfunction

	task automatic send_transaction(input mft_pkg::item_t it);
		if (burst_left == 0) begin
			if ($urandom_range(0, 2) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		req_valid <= 1'b1;
		kind <= it.kind;
		msg_type <= it.msg_type;
		data_id <= it.data_id;
		data_value <= it.data_value;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_transaction(it);
		burst_left--;
	endtask

	always @(posedge clk) begin : result_monitor
		mft_pkg::res_t got;
		if (arst_n && res_valid && !res_stall) begin
			got.line_level = line_level;
			got.busy_res = busy_res;
			got.accepted = accepted;
			got.frame_end = frame_end;
			sb.check_result(got);
			results_seen++;
		end
	end

	initial begin : stall_pattern
		stall_mode_t mode;
		int unsigned left;
		bit holdoff_done;
		mode = STALL_NONE;
		left = 0;
		holdoff_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
				holdoff_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 150);
			end
			left--;
			case (mode)
				STALL_NONE: begin
					res_stall <= 1'b0;
				end
				STALL_LIGHT: begin
					res_stall <= ($urandom_range(0, 3) == 0);
				end
				STALL_HEAVY: begin
					res_stall <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					res_stall <= (left % 3 == 0);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned counted;
		counted = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_transaction(tick_item());
		send_transaction(tick_item());
		send_transaction(request_item(3'h7, 8'hFF, 16'hFFFF));
		send_transaction(request_item(3'h0, 8'h00, 16'h0000));
		repeat (3) send_transaction(tick_item());
		send_transaction(request_item(3'h5, 8'hA5, 16'h5A5A));
		repeat (5) send_transaction(tick_item());
		send_transaction(request_item(3'h2, 8'h3C, 16'hC3C3));
		repeat (4) send_transaction(tick_item());
		send_transaction(request_item(3'h0, 8'h00, 16'h0000));

		while (counted < SEND_TARGET) begin
			if (!sb.sending) begin
				if ($urandom_range(0, 9) == 0) begin
					send_transaction(tick_item());
				end else begin
					send_transaction(random_request());
					counted++;
				end
			end else begin
				if ($urandom_range(0, 19) == 0) begin
					send_transaction(random_request());
				end else begin
					send_transaction(tick_item());
					counted++;
				end
			end
		end
		req_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
